### hdl/zsc_pkg.sv
// Package: shared types and constants of the zero-strip chunk compressor.
`timescale 1ns / 1ps

package zsc_pkg;

    // Field widths fixed by the item format
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int TOTAL_W = 16;

    // Input item kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Strip direction codes
    localparam logic CUT_HEAD = 1'b0;
    localparam logic CUT_TAIL = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    // One result beat
    typedef struct packed {
        logic              status;
        logic              is_header;
        logic              tail_cut;
        logic [LEN_W-1:0]  kept_length;
        logic [BYTE_W-1:0] kept_byte;
        logic              last;
    } result_t;

endpackage

### hdl/zsc_in_if.sv
// Interface: input item channel (data byte or restart).
`timescale 1ns / 1ps

interface zsc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [zsc_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_call;

    modport source (output valid, output kind, output data_byte, output end_of_call,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input end_of_call,
                    output ready);
endinterface

### hdl/zsc_out_if.sv
// Interface: result channel (chunk header, kept bytes, reject status).
`timescale 1ns / 1ps

interface zsc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic                       is_header;
    logic                       tail_cut;
    logic [zsc_pkg::LEN_W-1:0]  kept_length;
    logic [zsc_pkg::BYTE_W-1:0] kept_byte;
    logic                       last;

    modport source (output valid, output status, output is_header, output tail_cut,
                    output kept_length, output kept_byte, output last, input ready);
    modport sink   (input valid, input status, input is_header, input tail_cut,
                    input kept_length, input kept_byte, input last, output ready);
endinterface

### hdl/zsc_cfg_if.sv
// Interface: configuration write channel for the expected byte total.
`timescale 1ns / 1ps

interface zsc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [zsc_pkg::TOTAL_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/zero_strip_chunk_compressor.sv
// Top level: zero-strip chunk compressor with chunk memory and emit sequencer.
//
//  channel   role    beat contents
//  -------   -----   ---------------------------------------------------------
//  items     sink    kind, data_byte, end_of_call (end_of_call has no effect)
//  results   source  status, is_header, tail_cut, kept_length, kept_byte, last
//  cfg       sink    data = expected_total_bytes, ready always high
//
//  A data byte that does not close a chunk, a restart, or a rejected byte leaves the sequencer idle.
//  A closing byte loads the header at once; each kept byte then passes through ST_READ (memory
//  read) and ST_LOAD (load into the result register, held while the results channel stalls).
//  Leading/trailing zero runs are counted as bytes arrive.
//  Reset clears counters and the result valid flag; memory is not cleared.
//  A stalled results channel holds the sequencer and, through it, the items channel.
`timescale 1ns / 1ps

module zero_strip_chunk_compressor #(
    parameter int CHUNK_BYTES = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    zsc_in_if.sink   items,
    zsc_out_if.source results,
    zsc_cfg_if.sink  cfg
);

    localparam int FILL_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int CNT_W  = $clog2(CHUNK_BYTES + 1);
    localparam int CMP_W  = (COUNT_BITS > zsc_pkg::TOTAL_W) ? COUNT_BITS : zsc_pkg::TOTAL_W;

    localparam logic [FILL_W-1:0]     FILL_LAST  = FILL_W'(CHUNK_BYTES - 1);
    localparam logic [FILL_W-1:0]     FILL_ONE   = FILL_W'(1);
    localparam logic [CNT_W-1:0]      CHUNK_LEN  = CNT_W'(CHUNK_BYTES);
    localparam logic [CNT_W-1:0]      CNT_ONE    = CNT_W'(1);
    localparam logic [COUNT_BITS-1:0] RECV_ONE   = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] RECV_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [zsc_pkg::BYTE_W-1:0] ZERO_BYTE = '0;

    // Chunk memory
    logic [zsc_pkg::BYTE_W-1:0] mem [CHUNK_BYTES];
    logic [zsc_pkg::BYTE_W-1:0] rd_data_reg;

    // Control and counters
    zsc_pkg::state_t state_reg, state_next;
    logic [zsc_pkg::TOTAL_W-1:0] expected_reg;
    logic [COUNT_BITS-1:0]       recv_reg, recv_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [CNT_W-1:0]            lead_reg, lead_next;
    logic [CNT_W-1:0]            trail_reg, trail_next;
    logic [FILL_W-1:0]           rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]            remain_reg, remain_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    zsc_pkg::result_t out_reg, out_next;

    // Decoded strobes
    logic             out_free;
    logic             item_acc;
    logic             is_data;
    logic             reject;
    logic             store;
    logic             closes;
    logic             mem_rd;
    logic             load_byte;
    logic [CNT_W-1:0] lead_new;
    logic [CNT_W-1:0] trail_new;
    logic             dir;
    logic [CNT_W-1:0] kept_len;
    logic [FILL_W-1:0] start_addr;

    assign out_free = !out_valid_reg || results.ready;
    assign item_acc = items.valid && items.ready;
    assign is_data  = (items.kind == zsc_pkg::KIND_DATA);
    assign reject   = (CMP_W'(recv_reg) >= CMP_W'(expected_reg)) || (recv_reg == RECV_MAX);
    assign store    = item_acc && is_data && !reject;
    assign closes   = store && (fill_reg == FILL_LAST);

    // Zero-run update for the byte being stored
    always_comb
    begin
        if ((items.data_byte == ZERO_BYTE) && (lead_reg == CNT_W'(fill_reg)))
            lead_new = lead_reg + CNT_ONE;
        else
            lead_new = lead_reg;
        if (items.data_byte == ZERO_BYTE)
            trail_new = trail_reg + CNT_ONE;
        else
            trail_new = '0;
        dir = (lead_new >= trail_new) ? zsc_pkg::CUT_HEAD : zsc_pkg::CUT_TAIL;
        if (dir == zsc_pkg::CUT_HEAD)
        begin
            kept_len   = CHUNK_LEN - lead_new;
            start_addr = FILL_W'(lead_new);
        end
        else
        begin
            kept_len   = CHUNK_LEN - trail_new;
            start_addr = '0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            zsc_pkg::ST_IDLE:
                if (closes && (kept_len != '0))
                    state_next = zsc_pkg::ST_READ;
            zsc_pkg::ST_READ:
                state_next = zsc_pkg::ST_LOAD;
            zsc_pkg::ST_LOAD:
                if (out_free)
                    state_next = (remain_reg == CNT_ONE) ? zsc_pkg::ST_IDLE : zsc_pkg::ST_READ;
            default:
                state_next = zsc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        items.ready = 1'b0;
        mem_rd      = 1'b0;
        load_byte   = 1'b0;
        unique case (state_reg)
            zsc_pkg::ST_IDLE: items.ready = out_free;
            zsc_pkg::ST_READ: mem_rd      = 1'b1;
            zsc_pkg::ST_LOAD: load_byte   = out_free;
            default:          items.ready = 1'b0;
        endcase
    end

    assign cfg.ready = 1'b1;

    // Counters and emit pointers
    always_comb
    begin
        recv_next    = recv_reg;
        fill_next    = fill_reg;
        lead_next    = lead_reg;
        trail_next   = trail_reg;
        rd_addr_next = rd_addr_reg;
        remain_next  = remain_reg;
        if (item_acc && !is_data)
        begin
            recv_next  = '0;
            fill_next  = '0;
            lead_next  = '0;
            trail_next = '0;
        end
        else if (store)
        begin
            recv_next = recv_reg + RECV_ONE;
            if (closes)
            begin
                fill_next    = '0;
                lead_next    = '0;
                trail_next   = '0;
                rd_addr_next = start_addr;
                remain_next  = kept_len;
            end
            else
            begin
                fill_next  = fill_reg + FILL_ONE;
                lead_next  = lead_new;
                trail_next = trail_new;
            end
        end
        if (mem_rd)
            rd_addr_next = rd_addr_reg + FILL_ONE;
        if (load_byte)
            remain_next = remain_reg - CNT_ONE;
    end

    // Result register contents
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !results.ready;
        priority if (item_acc && is_data && reject)
        begin
            out_next        = '0;
            out_next.status = zsc_pkg::STATUS_REJECT;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
        end
        else if (closes)
        begin
            out_next             = '0;
            out_next.is_header   = 1'b1;
            out_next.tail_cut    = dir;
            out_next.kept_length = zsc_pkg::LEN_W'(kept_len);
            out_next.last        = (kept_len == '0);
            out_valid_next       = 1'b1;
        end
        else if (load_byte)
        begin
            out_next           = '0;
            out_next.kept_byte = rd_data_reg;
            out_next.last      = (remain_reg == CNT_ONE);
            out_valid_next     = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zsc_pkg::ST_IDLE;
            expected_reg  <= '0;
            recv_reg      <= '0;
            fill_reg      <= '0;
            lead_reg      <= '0;
            trail_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            recv_reg      <= recv_next;
            fill_reg      <= fill_next;
            lead_reg      <= lead_next;
            trail_reg     <= trail_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                expected_reg <= cfg.data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        rd_addr_reg <= rd_addr_next;
    end

    // Chunk memory: write while idle, read while emitting
    always_ff @(posedge clk)
    begin
        if (store)
            mem[fill_reg] <= items.data_byte;
        if (mem_rd)
            rd_data_reg <= mem[rd_addr_reg];
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = out_reg.status;
    assign results.is_header   = out_reg.is_header;
    assign results.tail_cut    = out_reg.tail_cut;
    assign results.kept_length = out_reg.kept_length;
    assign results.kept_byte   = out_reg.kept_byte;
    assign results.last        = out_reg.last;

    // Items are taken only while the sequencer is idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |-> (state_reg == zsc_pkg::ST_IDLE))
        else $error("item accepted while emitting a chunk");

    // Emitting always has bytes left to send
    a_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != zsc_pkg::ST_IDLE) |-> (remain_reg != '0))
        else $error("emit sequencer running with no bytes left");

    // A closing byte puts a header in the result register
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        closes |=> (out_valid_reg && out_reg.is_header))
        else $error("chunk closed without a header");

    // Zero runs never exceed the bytes gathered so far
    a_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (lead_reg <= CNT_W'(fill_reg)) && (trail_reg <= CNT_W'(fill_reg)))
        else $error("zero run count beyond fill level");

    // A kept-byte beat marked last ends the emit sequence
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load_byte && (remain_reg == CNT_ONE)) |=> (state_reg == zsc_pkg::ST_IDLE))
        else $error("sequencer kept running after last byte");

endmodule

### sim/zero_strip_chunk_compressor_tb.sv
// Testbench: random and directed byte streams checked against a zero-strip chunk predictor.
`timescale 1ns / 1ps

module zero_strip_chunk_compressor_tb;

    localparam int CHUNK_BYTES = 32;
    localparam int ITEM_TARGET = 500;
    localparam int LONG_HOLD   = 400;
    localparam int IDLE_GAP    = 8;
    localparam int END_WAIT    = 100;
    localparam int CYCLE_LIMIT = 400000;

    // One input beat as queued for the driver
    typedef struct {
        logic                       kind;
        logic [zsc_pkg::BYTE_W-1:0] data_byte;
        logic                       end_of_call;
    } item_t;

    // Chunk contents the stimulus generator can build
    typedef enum int {
        SHAPE_ZERO,
        SHAPE_DENSE,
        SHAPE_LEAD,
        SHAPE_TRAIL,
        SHAPE_TIE,
        SHAPE_LONE,
        SHAPE_SPECKLED,
        SHAPE_COUNT
    } chunk_shape_t;

    // Receiver back-pressure styles
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    zsc_in_if  in_ch ();
    zsc_out_if out_ch ();
    zsc_cfg_if cfg_ch ();

    zero_strip_chunk_compressor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (in_ch),
        .results (out_ch),
        .cfg     (cfg_ch)
    );

    always #6 clk = ~clk;

    // Predictor state
    logic [zsc_pkg::BYTE_W-1:0]  chunk_copy [CHUNK_BYTES];
    int                          chunk_fill = 0;
    logic [zsc_pkg::TOTAL_W-1:0] byte_count = '0;
    logic [zsc_pkg::TOTAL_W-1:0] total_limit = '0;
    zsc_pkg::result_t            due_results [$];

    item_t pending_items [$];

    // Bookkeeping
    int errors = 0;
    int results_seen = 0;
    int items_taken = 0;
    int restarts_taken = 0;
    int headers_due = 0;
    int kept_due = 0;
    int rejects_due = 0;
    int totals_written = 0;
    int stim_data = 0;

    // Driver pacing
    int   burst_left = 1;
    int   gap_left = 0;
    logic beat_taken;

    // Receiver pacing
    int       hold_req = 0;
    int       hold_ack = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    logic [7:0] stall_pat = 8'h5A;

    int cycles;

    // Work out the result beats caused by one accepted input beat
    task automatic compress_item(input item_t it);
        int               lead;
        int               trail;
        int               keep;
        int               first;
        zsc_pkg::result_t r;
        if (it.kind == zsc_pkg::KIND_RESTART) begin
            chunk_fill = 0;
            byte_count = '0;
            return;
        end
        // byte past the allowed total: dropped, single error beat
        if (byte_count >= total_limit || byte_count == {zsc_pkg::TOTAL_W{1'b1}}) begin
            r = '0;
            r.status = zsc_pkg::STATUS_REJECT;
            r.last = 1'b1;
            due_results.push_back(r);
            rejects_due++;
            return;
        end
        chunk_copy[chunk_fill] = it.data_byte;
        chunk_fill++;
        byte_count = byte_count + 16'd1;
        if (chunk_fill < CHUNK_BYTES)
            return;
        chunk_fill = 0;

        lead = 0;
        while (lead < CHUNK_BYTES && chunk_copy[lead] == 8'h00)
            lead++;
        trail = 0;
        while (trail < CHUNK_BYTES && chunk_copy[CHUNK_BYTES - 1 - trail] == 8'h00)
            trail++;

        // leading run wins a tie
        r = '0;
        r.status = zsc_pkg::STATUS_OK;
        r.is_header = 1'b1;
        if (lead >= trail) begin
            r.tail_cut = zsc_pkg::CUT_HEAD;
            keep = CHUNK_BYTES - lead;
            first = lead;
        end
        else begin
            r.tail_cut = zsc_pkg::CUT_TAIL;
            keep = CHUNK_BYTES - trail;
            first = 0;
        end
        r.kept_length = keep[zsc_pkg::LEN_W-1:0];
        r.last = (keep == 0);
        due_results.push_back(r);
        headers_due++;

        for (int i = 0; i < keep; i++) begin
            r = '0;
            r.status = zsc_pkg::STATUS_OK;
            r.kept_byte = chunk_copy[first + i];
            r.last = (i == keep - 1);
            due_results.push_back(r);
            kept_due++;
        end
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: result beat %0d, %s expected 0x%0h actual 0x%0h",
                     $time, results_seen, fname, want, got);
            errors++;
        end
    endtask

    // Monitor: predict on accepted input beats, check accepted result beats
    always @(posedge clk) begin : monitor
        zsc_pkg::result_t want;
        zsc_pkg::result_t got;
        item_t            seen;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                total_limit = cfg_ch.data;

            if (in_ch.valid && in_ch.ready) begin
                seen.kind = in_ch.kind;
                seen.data_byte = in_ch.data_byte;
                seen.end_of_call = in_ch.end_of_call;
                items_taken++;
                if (seen.kind == zsc_pkg::KIND_RESTART)
                    restarts_taken++;
                compress_item(seen);
            end

            if (out_ch.valid && out_ch.ready) begin
                got.status = out_ch.status;
                got.is_header = out_ch.is_header;
                got.tail_cut = out_ch.tail_cut;
                got.kept_length = out_ch.kept_length;
                got.kept_byte = out_ch.kept_byte;
                got.last = out_ch.last;
                if (due_results.size() == 0) begin
                    $display("%0t ns: result beat %0d with none expected, actual %0h",
                             $time, results_seen, got);
                    errors++;
                end
                else begin
                    want = due_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("is_header", 32'(want.is_header), 32'(got.is_header));
                    check_field("tail_cut", 32'(want.tail_cut), 32'(got.tail_cut));
                    check_field("kept_length", 32'(want.kept_length),
                                32'(got.kept_length));
                    check_field("kept_byte", 32'(want.kept_byte), 32'(got.kept_byte));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
                results_seen++;
            end
        end
    end

    // Driver: offers queued beats in bursts with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.kind <= zsc_pkg::KIND_DATA;
            in_ch.data_byte <= '0;
            in_ch.end_of_call <= 1'b0;
        end
        else begin
            beat_taken = in_ch.valid && in_ch.ready;
            if (beat_taken) begin
                void'(pending_items.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            // a beat on offer stays until taken
            if (!in_ch.valid || beat_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= pending_items[0].kind;
                    in_ch.data_byte <= pending_items[0].data_byte;
                    in_ch.end_of_call <= pending_items[0].end_of_call;
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern of its own, plus one long hold on request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(16, 160);
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                stall_pat = 8'($urandom_range(1, 255));
            end
            else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   out_ch.ready <= stall_pat[0];
            endcase
            stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
    end

    // Watchdog
    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("%0t ns: timeout with %0d result beats still due", $time, due_results.size());
        $display("zero_strip_chunk_compressor_tb: errors");
        $finish;
    end

    task automatic queue_byte(input logic [zsc_pkg::BYTE_W-1:0] v);
        item_t it;
        it.kind = zsc_pkg::KIND_DATA;
        it.data_byte = v;
        it.end_of_call = ($urandom_range(0, 3) == 0);
        pending_items.push_back(it);
        stim_data++;
    endtask

    task automatic queue_restart();
        item_t it;
        it.kind = zsc_pkg::KIND_RESTART;
        it.data_byte = 8'($urandom_range(0, 255));
        it.end_of_call = 1'($urandom_range(0, 1));
        pending_items.push_back(it);
    endtask

    // Build one full chunk of the given zero layout with random body bytes
    task automatic queue_chunk(input chunk_shape_t shape);
        logic [zsc_pkg::BYTE_W-1:0] b [CHUNK_BYTES];
        int nl;
        int nt;
        int pos;
        nl = 0;
        nt = 0;
        for (int i = 0; i < CHUNK_BYTES; i++)
            b[i] = 8'($urandom_range(0, 255));
        case (shape)
            SHAPE_ZERO: begin
                for (int i = 0; i < CHUNK_BYTES; i++)
                    b[i] = 8'h00;
            end
            SHAPE_LONE: begin
                pos = $urandom_range(0, CHUNK_BYTES - 1);
                for (int i = 0; i < CHUNK_BYTES; i++)
                    b[i] = 8'h00;
                b[pos] = 8'($urandom_range(1, 255));
            end
            SHAPE_SPECKLED: begin
                for (int i = 0; i < CHUNK_BYTES; i++)
                    if ($urandom_range(0, 1) == 0)
                        b[i] = 8'h00;
            end
            default: begin
                // leading/trailing runs, body ends forced nonzero
                if (shape == SHAPE_LEAD) begin
                    nl = $urandom_range(1, CHUNK_BYTES - 1);
                    nt = $urandom_range(0, (nl - 1 < CHUNK_BYTES - 1 - nl)
                                           ? nl - 1 : CHUNK_BYTES - 1 - nl);
                end
                else if (shape == SHAPE_TRAIL) begin
                    nt = $urandom_range(1, CHUNK_BYTES - 1);
                    nl = $urandom_range(0, (nt - 1 < CHUNK_BYTES - 1 - nt)
                                           ? nt - 1 : CHUNK_BYTES - 1 - nt);
                end
                else if (shape == SHAPE_TIE) begin
                    nl = $urandom_range(1, (CHUNK_BYTES - 1) / 2);
                    nt = nl;
                end
                for (int i = 0; i < nl; i++)
                    b[i] = 8'h00;
                for (int i = 0; i < nt; i++)
                    b[CHUNK_BYTES - 1 - i] = 8'h00;
                if (b[nl] == 8'h00)
                    b[nl] = 8'($urandom_range(1, 255));
                if (b[CHUNK_BYTES - 1 - nt] == 8'h00)
                    b[CHUNK_BYTES - 1 - nt] = 8'($urandom_range(1, 255));
            end
        endcase
        for (int i = 0; i < CHUNK_BYTES; i++)
            queue_byte(b[i]);
    endtask

    // Wait until every queued beat is in and every due result is out
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_ch.valid || due_results.size() != 0);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic set_total(input logic [zsc_pkg::TOTAL_W-1:0] v);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        totals_written++;
    endtask

    // Stimulus sequence
    initial begin : stimulus
        logic [zsc_pkg::TOTAL_W-1:0] total_pick;
        int phase;
        int chunks;
        int shape_turn;
        phase = 0;
        shape_turn = 0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // total still zero from reset: any byte is rejected
        queue_byte(8'hFF);
        queue_restart();
        drain();

        // total of two: third byte rejected mid-chunk
        set_total(16'd2);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_restart();
        drain();

        // widest total; short partial chunk dropped by restart
        set_total(16'hFFFF);
        queue_byte(8'h01);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_restart();
        drain();

        // random messages over a spread of totals
        while (stim_data < ITEM_TARGET) begin
            case (phase % 5)
                0: total_pick = 16'hFFFF;
                1: total_pick = 16'($urandom_range(1, 100));
                2: total_pick = 16'(CHUNK_BYTES * $urandom_range(1, 4));
                3: total_pick = 16'h0000;
                default: total_pick = 16'($urandom_range(101, 65534));
            endcase
            set_total(total_pick);
            queue_restart();
            if (total_pick == 16'h0000) begin
                repeat ($urandom_range(2, 6))
                    queue_byte(8'($urandom_range(0, 255)));
            end
            else begin
                chunks = (phase == 0) ? 6 : $urandom_range(1, 4);
                repeat (chunks) begin
                    if ($urandom_range(0, 7) == 0) begin
                        // broken chunk cut off by a restart
                        repeat ($urandom_range(1, CHUNK_BYTES - 1))
                            queue_byte(8'($urandom_range(0, 255)));
                        queue_restart();
                    end
                    else begin
                        queue_chunk(chunk_shape_t'(shape_turn % SHAPE_COUNT));
                        shape_turn++;
                    end
                end
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 5))
                        queue_byte(8'($urandom_range(0, 255)));
            end
            // first random phase: long receiver hold while input keeps coming
            if (phase == 0)
                hold_req++;
            drain();
            phase++;
        end

        repeat (END_WAIT) @(posedge clk);
        $display("Covered %0d input beats (%0d restarts) across %0d byte-total settings.",
                 items_taken, restarts_taken, totals_written);
        $display("Checked %0d result beats: %0d chunk headers, %0d kept bytes, %0d rejects.",
                 results_seen, headers_due, kept_due, rejects_due);
        if (errors == 0)
            $display("zero_strip_chunk_compressor_tb: clean");
        else
            $display("zero_strip_chunk_compressor_tb: errors");
        $finish;
    end

endmodule

### sim.f
hdl/zsc_pkg.sv
hdl/zsc_in_if.sv
hdl/zsc_out_if.sv
hdl/zsc_cfg_if.sv
hdl/zero_strip_chunk_compressor.sv
sim/zero_strip_chunk_compressor_tb.sv
